FILE: hdl/dpd_pkg.sv
// Shared types, character codes and the hex digit decoder for the packet deframer.
// No dependencies; every other file of the block imports this package.
package dpd_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ESCAPE = 8'h7D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_INTR   = 8'h03;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [0:0]  REG_ACK_ENABLED = 1'b0;

    typedef enum logic [2:0] {
        PH_WAIT_ACK    = 3'd0,
        PH_WAIT_DOLLAR = 3'd1,
        PH_PAYLOAD     = 3'd2,
        PH_ESCAPE      = 3'd3,
        PH_CSUM_HI     = 3'd4,
        PH_CSUM_LO     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_PAYLOAD = 3'd0,
        EV_END     = 3'd1,
        EV_ACK     = 3'd2,
        EV_INTR    = 3'd3,
        EV_CLOSE   = 3'd4
    } t_event;

    typedef struct packed {
        t_event     kind;
        logic [7:0] payload_byte;
        logic [7:0] checksum_value;
        logic [1:0] checksum_digits;
        logic       checksum_hex_bad;
        logic       ack_with_packet;
    } t_result;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } t_nibble;

    // A character that is not a hex digit decodes as zero with the bad flag set.
    function automatic t_nibble hex_nibble(input logic [7:0] c);
        t_nibble r;
        r.bad   = 1'b0;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r.value = c[3:0] + 4'd9;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hdl/dpd_cfg.sv
// APB-style configuration register file holding the ack mode bit.
// Depends on dpd_pkg for the address width and register index.
module dpd_cfg
    import dpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  o_ack_enabled
);

    logic r_ack_enabled;
    logic n_ack_enabled;
    logic hit;

    assign hit    = (paddr[APB_ADDR_W-1:2] == REG_ACK_ENABLED);
    assign pready = 1'b1;

    always_comb begin
        n_ack_enabled = r_ack_enabled;
        if (psel && penable && pwrite && hit) begin
            n_ack_enabled = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_enabled <= 1'b1;
        end else begin
            r_ack_enabled <= n_ack_enabled;
        end
    end

    assign prdata        = hit ? {{(APB_DATA_W-1){1'b0}}, r_ack_enabled} : '0;
    assign o_ack_enabled = r_ack_enabled;

endmodule

FILE: hdl/dpd_core.sv
// Input byte register, parse phase state and per-byte decode of the deframer.
// Depends on dpd_pkg for phase, event and result types and the hex decoder.
module dpd_core
    import dpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    output logic       o_in_stall,
    input  logic       i_ack_enabled,
    input  logic       i_res_ready,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_in_byte;
    t_phase     r_phase;
    t_phase     n_phase;
    logic [3:0] r_csum_hi;
    logic [3:0] n_csum_hi;
    logic       r_hex_err;
    logic       n_hex_err;
    logic       has_res;
    logic       take;
    logic       accept;
    t_nibble    nib;
    t_result    res;
    logic [7:0] c;

    assign c      = r_in_byte;
    assign nib    = hex_nibble(c);
    assign take   = r_in_valid && (!has_res || i_res_ready);
    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !take;

    // Next phase and checksum state.
    always_comb begin
        n_phase   = r_phase;
        n_csum_hi = r_csum_hi;
        n_hex_err = r_hex_err;
        case (r_phase)
            PH_PAYLOAD: begin
                if (c == CH_ESCAPE) begin
                    n_phase = PH_ESCAPE;
                end else if (c == CH_HASH) begin
                    n_phase = PH_CSUM_HI;
                end
            end
            PH_ESCAPE: begin
                n_phase = PH_PAYLOAD;
            end
            PH_CSUM_HI: begin
                if (c == CH_DOLLAR) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_csum_hi = nib.value;
                    n_hex_err = nib.bad;
                    n_phase   = PH_CSUM_LO;
                end
            end
            PH_CSUM_LO: begin
                n_phase = (c == CH_DOLLAR) ? PH_PAYLOAD : PH_WAIT_DOLLAR;
            end
            PH_WAIT_ACK: begin
                if (!(i_ack_enabled && c != CH_PLUS) && c == CH_DOLLAR) begin
                    n_phase = PH_PAYLOAD;
                end
            end
            default: begin
                if (c == CH_DOLLAR) begin
                    n_phase = PH_PAYLOAD;
                end
            end
        endcase
    end

    // Result for the byte held in the input register.
    always_comb begin
        has_res = 1'b0;
        res     = '0;
        res.kind = EV_PAYLOAD;
        case (r_phase)
            PH_PAYLOAD: begin
                if (c == CH_DOLLAR) begin
                    has_res             = 1'b1;
                    res.kind            = EV_END;
                    res.ack_with_packet = i_ack_enabled;
                end else if (c != CH_ESCAPE && c != CH_HASH) begin
                    has_res          = 1'b1;
                    res.payload_byte = c;
                end
            end
            PH_ESCAPE: begin
                has_res          = 1'b1;
                res.payload_byte = c ^ ESC_XOR;
            end
            PH_CSUM_HI: begin
                if (c == CH_DOLLAR) begin
                    has_res             = 1'b1;
                    res.kind            = EV_END;
                    res.ack_with_packet = i_ack_enabled;
                end
            end
            PH_CSUM_LO: begin
                has_res             = 1'b1;
                res.kind            = EV_END;
                res.ack_with_packet = i_ack_enabled;
                if (c == CH_DOLLAR) begin
                    res.checksum_value   = {r_csum_hi, 4'd0};
                    res.checksum_digits  = 2'd1;
                    res.checksum_hex_bad = r_hex_err;
                end else begin
                    res.checksum_value   = {r_csum_hi, nib.value};
                    res.checksum_digits  = 2'd2;
                    res.checksum_hex_bad = r_hex_err | nib.bad;
                end
            end
            default: begin
                // Waiting for '$', and waiting for an ack that passes through.
                if (r_phase == PH_WAIT_ACK && i_ack_enabled && c != CH_PLUS) begin
                    has_res  = 1'b1;
                    res.kind = EV_CLOSE;
                end else if (c == CH_PLUS) begin
                    has_res  = 1'b1;
                    res.kind = EV_ACK;
                end else if (c == CH_INTR) begin
                    has_res  = 1'b1;
                    res.kind = EV_INTR;
                end
            end
        endcase
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (take) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_WAIT_ACK;
            r_csum_hi  <= 4'd0;
            r_hex_err  <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (take) begin
                r_phase   <= n_phase;
                r_csum_hi <= n_csum_hi;
                r_hex_err <= n_hex_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
        end
    end

    assign o_res_valid = r_in_valid && has_res;
    assign o_res       = res;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_result_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && has_res) |-> i_res_ready)
        else $error("result consumed while the result register was full");

    a_escape_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase == PH_ESCAPE) |=> (r_phase == PH_PAYLOAD))
        else $error("escaped byte did not return to payload phase");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind != EV_END) |-> (o_res.checksum_digits == 2'd0))
        else $error("checksum digits reported outside a packet end");

endmodule

FILE: hdl/dpd_out_stage.sv
// Result register between the decode logic and the output channel.
// Depends on dpd_pkg for the result struct.
module dpd_out_stage
    import dpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_res_ready,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_res_ready) begin
            n_valid = i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_res;

endmodule

FILE: hdl/debug_packet_deframer_top.sv
// Remote-debug packet deframer: splits a byte stream into $payload#hh packets.
// Path: a byte transfer lands in the input register, is decoded from there, and
// its result is then offered from the result register.
// Throughput: one byte per cycle unless a byte with a result meets a full, stalled result register.
// Reset (synchronous, active low): waiting for ack, ack mode on, both registers empty.
// Depends on dpd_pkg, dpd_cfg, dpd_core and dpd_out_stage.
module debug_packet_deframer_top
    import dpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input byte channel.
    input  logic                  i_in_valid,
    input  logic [7:0]            i_in_byte,
    output logic                  o_in_stall,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_event_kind,
    output logic [7:0]            o_payload_byte,
    output logic [7:0]            o_checksum_value,
    output logic [1:0]            o_checksum_digits,
    output logic                  o_checksum_hex_bad,
    output logic                  o_ack_with_packet,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic    ack_enabled;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    t_result out;

    // The user must change the ack mode bit only while the block is idle, which the block
    // itself does not enforce; the decode stage reads it directly without any hand-off.
    dpd_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_ack_enabled (ack_enabled)
    );

    // The decode stage consumes its held byte only when that byte produces no
    // result or the result register can take one, so no result is dropped.
    dpd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_byte     (i_in_byte),
        .o_in_stall    (o_in_stall),
        .i_ack_enabled (ack_enabled),
        .i_res_ready   (res_ready),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // The result register lets a new byte enter while a finished result still
    // waits for its transfer.
    dpd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (out)
    );

    assign o_event_kind       = out.kind;
    assign o_payload_byte     = out.payload_byte;
    assign o_checksum_value   = out.checksum_value;
    assign o_checksum_digits  = out.checksum_digits;
    assign o_checksum_hex_bad = out.checksum_hex_bad;
    assign o_ack_with_packet  = out.ack_with_packet;

endmodule
